FILE: rtl/fsra_pkg.sv
// Shared types and constants of the feed success rate adapter.
`timescale 1ns / 1ps
package fsra_pkg;

  localparam int CntW  = 32;
  localparam int TimeW = 48;
  localparam int FactW = 10;
  localparam int StepW = 8;
  localparam int QuotW = 16;

  localparam logic [FactW-1:0] FACTOR_RESET = 10'd256;
  localparam logic [FactW-1:0] MIN_RESET    = 10'd128;
  localparam logic [FactW-1:0] MAX_RESET    = 10'd384;
  localparam logic [StepW-1:0] STEP_RESET   = 8'd13;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Request to the shared divider: remainder start, low dividend bits, divisor.
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] rem;
    logic [QuotW-1:0] low;
    logic [CntW-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/fsra_div.sv
// Shared restoring divider, one quotient bit per cycle, 16 bits per run.
`timescale 1ns / 1ps
module fsra_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsra_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [fsra_pkg::QuotW-1:0]    quot_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [fsra_pkg::CntW-1:0]     rem_q, rem_d;
  logic [fsra_pkg::QuotW-1:0]    low_q, low_d;
  logic [fsra_pkg::CntW-1:0]     den_q, den_d;
  logic [fsra_pkg::QuotW-1:0]    quot_q, quot_d;
  logic [fsra_pkg::CntW:0]       trial;
  logic [fsra_pkg::CntW:0]       diff;
  logic                          fits;

  assign trial = {rem_q, low_q[fsra_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'd15;
      rem_d  = req_i.rem;
      low_d  = req_i.low;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = fits ? diff[fsra_pkg::CntW-1:0] : trial[fsra_pkg::CntW-1:0];
      low_d  = {low_q[fsra_pkg::QuotW-2:0], 1'b0};
      quot_d = {quot_q[fsra_pkg::QuotW-2:0], fits};
      cnt_d  = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_last_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == 4'd0) |=> done_q)
    else $error("divider missed done after last step");

endmodule

FILE: rtl/feed_success_rate_adapter_top.sv
// Top level of the feed success rate adapter: registers, sequencer, channel state.
`timescale 1ns / 1ps
// One input beat reports a feed attempt (channel, success flag, feed time).
// One output beat returns status, new rate factor, success ratio and mean
// successful feed time for that channel. Both channels are valid/ready.
// Limits and step are set over the APB-style port (min 0x0, max 0x4,
// step 0x8); pready is always high. The user makes writes only while the
// block is idle; the block itself does not enforce this. After its input
// beat an in-range attempt passes one update step, two ratio compares, one
// factor adjust that also starts the ratio run, two 16-step runs of the
// shared restoring divider, each ending in a done strobe, one setup step
// before the mean run, one final step and the output register. With no
// successes, or a mean that saturates, the mean run is skipped. An
// out-of-range channel goes straight to the final step.
// One item is in work at a time; in_ready_o is high only when idle, so a
// new item waits until the last has left the sequencer. The result sits
// in an output register; a new item is taken while it waits, and the sequencer
// holds in its final state if the receiver still stalls the earlier beat.
// Reset clears all counters, sets every factor to 256 and the registers to
// their defaults.
module feed_success_rate_adapter_top #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  channel_i,
  input  logic        feed_success_i,
  input  logic [15:0] feed_time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [9:0]  rate_factor_o,
  output logic [16:0] success_ratio_o,
  output logic [15:0] mean_feed_time_ms_o
);

  localparam int CntW  = fsra_pkg::CntW;
  localparam int TimeW = fsra_pkg::TimeW;
  localparam int FactW = fsra_pkg::FactW;
  localparam int StepW = fsra_pkg::StepW;
  localparam int QuotW = fsra_pkg::QuotW;
  localparam int ChW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [3:0] NumCh = 4'(NUM_CHANNELS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_UPD   = 4'd1;
  localparam logic [3:0] ST_CMPLO = 4'd2;
  localparam logic [3:0] ST_CMPHI = 4'd3;
  localparam logic [3:0] ST_ADJ   = 4'd4;
  localparam logic [3:0] ST_DIVR  = 4'd5;
  localparam logic [3:0] ST_MCHK  = 4'd6;
  localparam logic [3:0] ST_DIVM  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // configuration
  logic [FactW-1:0] min_q, max_q;
  logic [StepW-1:0] step_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= fsra_pkg::MIN_RESET;
      max_q  <= fsra_pkg::MAX_RESET;
      step_q <= fsra_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fsra_pkg::REG_MIN:  min_q  <= pwdata[FactW-1:0];
        fsra_pkg::REG_MAX:  max_q  <= pwdata[FactW-1:0];
        fsra_pkg::REG_STEP: step_q <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fsra_pkg::REG_MIN:  prdata = {22'd0, min_q};
      fsra_pkg::REG_MAX:  prdata = {22'd0, max_q};
      fsra_pkg::REG_STEP: prdata = {24'd0, step_q};
      default:            prdata = 32'd0;
    endcase
  end

  // channel state
  logic [CntW-1:0]  att_q  [NUM_CHANNELS];
  logic [CntW-1:0]  suc_q  [NUM_CHANNELS];
  logic [TimeW-1:0] tot_q  [NUM_CHANNELS];
  logic [FactW-1:0] fact_q [NUM_CHANNELS];

  // item work registers
  logic [3:0]       state_q;
  logic [2:0]       ch_q;
  logic             ok_q;
  logic [15:0]      t_q;
  logic [CntW-1:0]  a_q, s_q;
  logic [TimeW-1:0] tt_q;
  logic [FactW-1:0] f_q;
  logic             lo_q, hi_q;
  logic             status_q;
  logic [16:0]      ratio_q;
  logic [15:0]      mean_q;

  logic [ChW-1:0]   idx;
  logic [CntW-1:0]  a_new, s_new;
  logic [TimeW:0]   tsum;
  logic [TimeW-1:0] t_new;
  logic [CntW+2:0]  s5, a4;
  logic [CntW+4:0]  s20, a19;
  logic [FactW:0]   f_dn, f_up;
  logic [FactW-1:0] f_new;
  logic             in_fire, out_free, s_eq_a;
  fsra_pkg::div_req_t div_req;
  logic             div_done;
  logic [QuotW-1:0] div_quot;

  assign idx      = ch_q[ChW-1:0];
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;

  assign a_new = (att_q[idx] == '1) ? att_q[idx] : att_q[idx] + 1'b1;
  assign s_new = (ok_q && suc_q[idx] != '1) ? suc_q[idx] + 1'b1 : suc_q[idx];
  assign tsum  = {1'b0, tot_q[idx]} + {33'd0, t_q};
  assign t_new = !ok_q ? tot_q[idx] : (tsum[TimeW] ? '1 : tsum[TimeW-1:0]);

  assign s5  = {3'b000, s_q} + {1'b0, s_q, 2'b00};
  assign a4  = {1'b0, a_q, 2'b00};
  assign s20 = {1'b0, s_q, 4'b0000} + {3'b000, s_q, 2'b00};
  assign a19 = {1'b0, a_q, 4'b0000} + {4'b0000, a_q, 1'b0} + {5'b00000, a_q};

  assign f_dn = {1'b0, f_q} - {3'b000, step_q};
  assign f_up = {1'b0, f_q} + {3'b000, step_q};
  assign s_eq_a = (s_q == a_q);

  always_comb begin
    f_new = f_q;
    if (lo_q && f_q > min_q) begin
      f_new = ($signed(f_dn) < $signed({1'b0, min_q})) ? min_q : f_dn[FactW-1:0];
    end else if (hi_q && f_q < max_q) begin
      f_new = (f_up > {1'b0, max_q}) ? max_q : f_up[FactW-1:0];
    end
  end

  always_comb begin
    div_req = '0;
    if (state_q == ST_ADJ) begin
      div_req.start = 1'b1;
      div_req.rem   = s_eq_a ? '0 : s_q;
      div_req.low   = '0;
      div_req.den   = a_q;
    end else if (state_q == ST_MCHK && s_q != '0 && tt_q[TimeW-1:QuotW] < s_q) begin
      div_req.start = 1'b1;
      div_req.rem   = tt_q[TimeW-1:QuotW];
      div_req.low   = tt_q[QuotW-1:0];
      div_req.den   = s_q;
    end
  end

  fsra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        att_q[i]  <= '0;
        suc_q[i]  <= '0;
        tot_q[i]  <= '0;
        fact_q[i] <= fsra_pkg::FACTOR_RESET;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ({1'b0, channel_i} >= NumCh) ? ST_FIN : ST_UPD;
          end
        end
        ST_UPD: begin
          att_q[idx] <= a_new;
          suc_q[idx] <= s_new;
          tot_q[idx] <= t_new;
          state_q    <= ST_CMPLO;
        end
        ST_CMPLO: state_q <= ST_CMPHI;
        ST_CMPHI: state_q <= ST_ADJ;
        ST_ADJ: begin
          fact_q[idx] <= f_new;
          state_q     <= ST_DIVR;
        end
        ST_DIVR: begin
          if (div_done) state_q <= ST_MCHK;
        end
        ST_MCHK: state_q <= div_req.start ? ST_DIVM : ST_FIN;
        ST_DIVM: begin
          if (div_done) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ch_q     <= channel_i;
          ok_q     <= feed_success_i;
          t_q      <= feed_time_ms_i;
          status_q <= ({1'b0, channel_i} >= NumCh) ? fsra_pkg::STATUS_ERR
                                                   : fsra_pkg::STATUS_OK;
          f_q      <= '0;
          ratio_q  <= '0;
          mean_q   <= '0;
        end
      end
      ST_UPD: begin
        a_q  <= a_new;
        s_q  <= s_new;
        tt_q <= t_new;
        f_q  <= fact_q[idx];
      end
      ST_CMPLO: lo_q <= s5 < a4;
      ST_CMPHI: hi_q <= s20 > a19;
      ST_ADJ: begin
        f_q         <= f_new;
        ratio_q[16] <= s_eq_a;
      end
      ST_DIVR: begin
        if (div_done) ratio_q[15:0] <= div_quot;
      end
      ST_MCHK: begin
        if (s_q == '0) mean_q <= '0;
        else if (!div_req.start) mean_q <= '1;
      end
      ST_DIVM: begin
        if (div_done) mean_q <= div_quot;
      end
      default: ;
    endcase
  end

  // output register
  logic        out_valid_q;
  logic        out_status_q;
  logic [9:0]  out_fact_q;
  logic [16:0] out_ratio_q;
  logic [15:0] out_mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_status_q <= status_q;
      out_fact_q   <= f_q;
      out_ratio_q  <= ratio_q;
      out_mean_q   <= mean_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign rate_factor_o       = out_fact_q;
  assign success_ratio_o     = out_ratio_q;
  assign mean_feed_time_ms_o = out_mean_q;

endmodule

FILE: bench/feed_success_rate_adapter_top_tb.sv
// Self-checking testbench of the feed success rate adapter top level.
`timescale 1ns / 1ps
module feed_success_rate_adapter_top_tb;

  localparam int NUM_CH = 4;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_LATENCY = 100;
  localparam int CntW  = fsra_pkg::CntW;
  localparam int TimeW = fsra_pkg::TimeW;
  localparam int FactW = fsra_pkg::FactW;
  localparam int StepW = fsra_pkg::StepW;
  localparam logic [63:0] TIME_CAP = (64'd1 << TimeW) - 64'd1;

  typedef struct packed {
    logic [2:0]  channel;
    logic        ok;
    logic [15:0] feed_ms;
  } attempt_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  factor;
    logic [16:0] ratio;
    logic [15:0] mean;
  } feed_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  channel_i = '0;
  logic        feed_success_i = 1'b0;
  logic [15:0] feed_time_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic [9:0]  rate_factor_o;
  logic [16:0] success_ratio_o;
  logic [15:0] mean_feed_time_ms_o;

  feed_success_rate_adapter_top #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .channel_i(channel_i),
    .feed_success_i(feed_success_i),
    .feed_time_ms_i(feed_time_ms_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .rate_factor_o(rate_factor_o),
    .success_ratio_o(success_ratio_o),
    .mean_feed_time_ms_o(mean_feed_time_ms_o)
  );

  // channel state and register copies
  logic [CntW-1:0]  attempts   [NUM_CH];
  logic [CntW-1:0]  successes  [NUM_CH];
  logic [TimeW-1:0] feed_total [NUM_CH];
  logic [FactW-1:0] factors    [NUM_CH];
  logic [FactW-1:0] cfg_min = fsra_pkg::MIN_RESET;
  logic [FactW-1:0] cfg_max = fsra_pkg::MAX_RESET;
  logic [StepW-1:0] cfg_step = fsra_pkg::STEP_RESET;

  attempt_t     attempt_queue[$];
  feed_result_t expected_results[$];
  attempt_t     next_beat;
  feed_result_t got;
  feed_result_t want;
  int           gap_pct = 37;
  int           err_count = 0;
  int           quiet_cycles = 0;
  int           success_pct[NUM_CH];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic feed_result_t predict_feed(input attempt_t a);
    feed_result_t r;
    logic [63:0] att, suc, tot, quo;
    int ch, fac, lo, hi, st;
    r = '{status: fsra_pkg::STATUS_ERR, factor: '0, ratio: '0, mean: '0};
    if (a.channel >= NUM_CH) return r;
    ch = a.channel;
    if (attempts[ch] != '1) attempts[ch] = attempts[ch] + 1'b1;
    if (a.ok) begin
      if (successes[ch] != '1) successes[ch] = successes[ch] + 1'b1;
      tot = 64'(feed_total[ch]) + 64'(a.feed_ms);
      feed_total[ch] = (tot > TIME_CAP) ? TIME_CAP[TimeW-1:0] : tot[TimeW-1:0];
    end
    att = 64'(attempts[ch]);
    suc = 64'(successes[ch]);
    fac = int'(factors[ch]);
    lo = int'(cfg_min);
    hi = int'(cfg_max);
    st = int'(cfg_step);
    if (5 * suc < 4 * att && fac > lo) begin
      fac = fac - st;
      if (fac < lo) fac = lo;
    end else if (20 * suc > 19 * att && fac < hi) begin
      fac = fac + st;
      if (fac > hi) fac = hi;
    end
    factors[ch] = fac[FactW-1:0];
    quo = (suc << 16) / att;
    r.status = fsra_pkg::STATUS_OK;
    r.factor = factors[ch];
    r.ratio = quo[16:0];
    if (suc == 0) begin
      r.mean = '0;
    end else begin
      quo = 64'(feed_total[ch]) / suc;
      r.mean = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
    end
    return r;
  endfunction

  function automatic attempt_t rand_attempt();
    attempt_t a;
    int ch;
    if ($urandom_range(99) < 10) ch = $urandom_range(7, NUM_CH);
    else ch = $urandom_range(NUM_CH - 1);
    a.channel = 3'(ch);
    a.ok = (ch < NUM_CH) ? ($urandom_range(99) < success_pct[ch % NUM_CH])
                         : 1'($urandom_range(1));
    case ($urandom_range(9))
      0: a.feed_ms = 16'h0000;
      1: a.feed_ms = 16'hFFFF;
      default: a.feed_ms = 16'($urandom);
    endcase
    return a;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val, input int w);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom << w) | val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fsra_pkg::REG_MIN: cfg_min = val[FactW-1:0];
      fsra_pkg::REG_MAX: cfg_max = val[FactW-1:0];
      fsra_pkg::REG_STEP: cfg_step = val[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int lo, input int hi, input int st);
    write_reg(fsra_pkg::REG_MIN, 32'(lo), FactW);
    write_reg(fsra_pkg::REG_MAX, 32'(hi), FactW);
    write_reg(fsra_pkg::REG_STEP, 32'(st), StepW);
  endtask

  task automatic wait_drained();
    while (attempt_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic push_attempt(input int ch, input bit ok, input int ms);
    attempt_queue.push_back('{channel: 3'(ch), ok: ok, feed_ms: 16'(ms)});
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (attempt_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_beat = attempt_queue.pop_front();
        in_valid_i <= 1'b1;
        channel_i <= next_beat.channel;
        feed_success_i <= next_beat.ok;
        feed_time_ms_i <= next_beat.feed_ms;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor, predictor hookup and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status: status_o, factor: rate_factor_o, ratio: success_ratio_o,
                mean: mean_feed_time_ms_o};
        if (expected_results.size() == 0) begin
          $error("result beat with no attempt outstanding");
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            err_count++;
          end
          if (got.factor !== want.factor) begin
            $error("rate_factor: expected %0d, actual %0d", want.factor, got.factor);
            err_count++;
          end
          if (got.ratio !== want.ratio) begin
            $error("success_ratio: expected %0d, actual %0d", want.ratio, got.ratio);
            err_count++;
          end
          if (got.mean !== want.mean) begin
            $error("mean_feed_time_ms: expected %0d, actual %0d", want.mean, got.mean);
            err_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_feed('{channel: channel_i, ok: feed_success_i,
                                                  feed_ms: feed_time_ms_i}));
      out_ready_i <= ($urandom_range(99) >= gap_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int lo_tab[NUM_PHASES];
    int hi_tab[NUM_PHASES];
    int st_tab[NUM_PHASES];
    int pct_tab[9];
    lo_tab = '{128, 0,    0,    1023, 1023, 0, 300, 0, 0, 0};
    hi_tab = '{384, 1023, 1023, 0,    1023, 0, 310, 0, 0, 0};
    st_tab = '{13,  255,  1,    255,  0,    7, 40,  0, 0, 0};
    pct_tab = '{0, 50, 79, 80, 81, 94, 95, 96, 100};
    for (int i = 0; i < NUM_CH; i++) begin
      attempts[i] = '0;
      successes[i] = '0;
      feed_total[i] = '0;
      factors[i] = fsra_pkg::FACTOR_RESET;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, out-of-range channels, climbs and drops
    push_attempt(0, 1, 0);
    push_attempt(0, 1, 65535);
    push_attempt(1, 0, 65535);
    push_attempt(4, 1, 65535);
    push_attempt(5, 0, 0);
    push_attempt(6, 1, 12345);
    push_attempt(7, 1, 65535);
    for (int i = 0; i < 7; i++) push_attempt(2, 1, 65535 - i);
    for (int i = 0; i < 7; i++) push_attempt(3, 0, i);
    for (int i = 0; i < 4; i++) push_attempt(1, i % 2, 40000);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p >= 7) begin
        lo_tab[p] = $urandom_range(1023);
        hi_tab[p] = $urandom_range(1023);
        st_tab[p] = $urandom_range(255);
      end
      set_limits(lo_tab[p], hi_tab[p], st_tab[p]);
      for (int c = 0; c < NUM_CH; c++) success_pct[c] = pct_tab[$urandom_range(8)];
      gap_pct = (p == 4) ? 0 : 37;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) attempt_queue.push_back(rand_attempt());
      wait_drained();
    end

    set_limits(fsra_pkg::MIN_RESET, fsra_pkg::MAX_RESET, fsra_pkg::STEP_RESET);
    repeat (END_LATENCY) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fsra_pkg.sv
rtl/fsra_div.sv
rtl/feed_success_rate_adapter_top.sv
bench/feed_success_rate_adapter_top_tb.sv
